>>> src/dexd_pkg.sv
// Package with the types, constants and opcode table of the DWARF expression decoder.
`default_nettype none

package dexd_pkg;

  // Width of the operand field of a result beat.
  localparam int OPERAND_OUT_W     = 64;
  // Default for the operand arithmetic width of the decoder.
  localparam int OPERAND_WIDTH_DEF = 64;
  // Bit position counter: covers 8 fixed bytes and up to ten LEB128 groups.
  localparam int BIT_POS_W         = 7;
  localparam int ADDR_BYTES_W      = 4;
  localparam logic [ADDR_BYTES_W-1:0] ADDR_BYTES_RESET = 4'd8;
  localparam logic [ADDR_BYTES_W-1:0] ADDR_BYTES_MIN   = 4'd4;
  localparam logic [ADDR_BYTES_W-1:0] ADDR_BYTES_MAX   = 4'd8;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_FIXED  = 2'd1,
    PH_LEB    = 2'd2,
    PH_OVER   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_FIXU = 3'd1,
    K_FIXS = 3'd2,
    K_ULEB = 3'd3,
    K_SLEB = 3'd4,
    K_BAD  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_UNSUP    = 2'd1,
    ERR_LEB_LONG = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_e;

  typedef struct packed {
    kind_e                   kind;
    logic [ADDR_BYTES_W-1:0] size;
  } op_class_t;

  // Operand form of an opcode; size is the byte count of fixed forms.
  function automatic op_class_t classify(input logic [7:0] op,
                                         input logic [ADDR_BYTES_W-1:0] addr_bytes);
    op_class_t c;
    c.kind = K_BAD;
    c.size = '0;
    if (op inside {[8'h30:8'h6f]}) begin
      c.kind = K_NONE;
    end else if (op inside {[8'h70:8'h8f]}) begin
      c.kind = K_SLEB;
    end else begin
      case (op)
        8'h06, 8'h12, 8'h13, 8'h14, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h24,
        8'h25, 8'h26, 8'h27, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e,
        8'h96, 8'h97, 8'h9b, 8'h9c: c.kind = K_NONE;
        8'h08, 8'h15, 8'h94, 8'h95: begin
          c.kind = K_FIXU; c.size = 4'd1;
        end
        8'h09: begin
          c.kind = K_FIXS; c.size = 4'd1;
        end
        8'h0a: begin
          c.kind = K_FIXU; c.size = 4'd2;
        end
        8'h0b, 8'h28, 8'h2f: begin
          c.kind = K_FIXS; c.size = 4'd2;
        end
        8'h0c: begin
          c.kind = K_FIXU; c.size = 4'd4;
        end
        8'h0d: begin
          c.kind = K_FIXS; c.size = 4'd4;
        end
        8'h0e: begin
          c.kind = K_FIXU; c.size = 4'd8;
        end
        8'h0f: begin
          c.kind = K_FIXS; c.size = 4'd8;
        end
        8'h03: begin
          // Address operand, size clamped to the supported range.
          c.kind = K_FIXU;
          if (addr_bytes < ADDR_BYTES_MIN) begin
            c.size = ADDR_BYTES_MIN;
          end else if (addr_bytes > ADDR_BYTES_MAX) begin
            c.size = ADDR_BYTES_MAX;
          end else begin
            c.size = addr_bytes;
          end
        end
        8'h10, 8'h23: c.kind = K_ULEB;
        8'h11, 8'h91: c.kind = K_SLEB;
        default: c.kind = K_BAD;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/dwarf_expression_decoder.sv
// Top level of the DWARF location expression decoder: byte stream in, instructions out.
// An input beat passes the input register and then the result register to the master side.
// Throughput: one input byte per cycle unless the output stalls, set by the single pass
// from the input register through the decode logic into the result register; a stalled
// output holds one result. Reset (rst_ni low, asynchronous) empties both registers, selects
// the opcode phase and sets the address size to eight bytes.
`default_nettype none

module dwarf_expression_decoder #(
  parameter int OPERAND_WIDTH = dexd_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration: address_bytes.
  input  wire logic                                 cfg_we_i,
  input  wire logic [dexd_pkg::ADDR_BYTES_W-1:0]    cfg_wdata_i,
  // Input stream.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,   // [7:0] data_byte
  input  wire logic                                 s_axis_tlast,   // end_of_expr
  // Instruction stream.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [dexd_pkg::OPERAND_OUT_W+7:0]        m_axis_tdata,   // [7:0] opcode,
                                                                    // [71:8] operand
  output logic [1:0]                                m_axis_tuser,   // [1:0] error_code
  output logic                                      m_axis_tlast    // last_instr
);

  import dexd_pkg::*;

  // A LEB128 longer than this many groups cannot fit the operand width.
  localparam int MAX_GROUPS = (OPERAND_WIDTH + 6) / 7;
  localparam int LEB_LIMIT  = 7 * MAX_GROUPS;
  localparam int IDX_W      = $clog2(OPERAND_WIDTH);

  // Configuration register.
  logic [ADDR_BYTES_W-1:0] addr_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_bytes_q <= ADDR_BYTES_RESET;
    end else if (cfg_we_i) begin
      addr_bytes_q <= cfg_wdata_i;
    end
  end

  // Input register. It is refilled in the same cycle that its beat moves on, so a
  // new byte is taken every cycle unless a result is stuck in the output register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       adv;

  assign adv           = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  // Decoder state.
  phase_e                   phase_q, phase_d;
  logic [7:0]               held_op_q, held_op_d;
  logic                     is_signed_q, is_signed_d;
  logic [ADDR_BYTES_W-1:0]  bytes_left_q, bytes_left_d;
  logic [OPERAND_WIDTH-1:0] acc_q, acc_d;
  logic [BIT_POS_W-1:0]     bit_pos_q, bit_pos_d;

  // Shared datapath: the current byte placed at the running bit position.
  op_class_t                cls;
  logic [7:0]               payload;
  logic [OPERAND_WIDTH-1:0] acc_new;
  logic [BIT_POS_W-1:0]     bp_new;
  logic [BIT_POS_W-1:0]     bp_m1;
  logic [ADDR_BYTES_W-1:0]  bytes_dec;
  logic                     fill;
  logic [OPERAND_WIDTH-1:0] value;
  logic                     leb_room;

  assign cls       = classify(in_byte_q, addr_bytes_q);
  // Fixed operands use whole bytes, LEB128 groups drop the continuation bit.
  assign payload   = (phase_q == PH_FIXED) ? in_byte_q : {1'b0, in_byte_q[6:0]};
  assign acc_new   = acc_q | (OPERAND_WIDTH'(payload) << bit_pos_q);
  assign bp_new    = bit_pos_q + ((phase_q == PH_FIXED) ? BIT_POS_W'(8) : BIT_POS_W'(7));
  assign bp_m1     = bp_new - BIT_POS_W'(1);
  assign bytes_dec = (bytes_left_q != '0) ? bytes_left_q - ADDR_BYTES_W'(1) : '0;
  assign leb_room  = bit_pos_q < BIT_POS_W'(LEB_LIMIT);

  // Signed forms narrower than the operand width extend from their top bit.
  assign fill  = is_signed_q && (bp_new < BIT_POS_W'(OPERAND_WIDTH)) &&
                 acc_new[bp_m1[IDX_W-1:0]];
  assign value = fill ? (acc_new | ({OPERAND_WIDTH{1'b1}} << bp_new)) : acc_new;

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    held_op_d    = held_op_q;
    is_signed_d  = is_signed_q;
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    bit_pos_d    = bit_pos_q;
    if (adv) begin
      case (phase_q)
        PH_OPCODE: begin
          if (cls.kind != K_NONE && cls.kind != K_BAD) begin
            held_op_d    = in_byte_q;
            is_signed_d  = (cls.kind == K_FIXS) || (cls.kind == K_SLEB);
            bytes_left_d = cls.size;
            acc_d        = '0;
            bit_pos_d    = '0;
            if (in_end_q) begin
              phase_d = PH_OPCODE;
            end else if (cls.kind == K_FIXU || cls.kind == K_FIXS) begin
              phase_d = PH_FIXED;
            end else begin
              phase_d = PH_LEB;
            end
          end
        end
        PH_FIXED: begin
          acc_d        = acc_new;
          bit_pos_d    = bp_new;
          bytes_left_d = bytes_dec;
          if (bytes_dec == '0 || in_end_q) begin
            phase_d = PH_OPCODE;
          end
        end
        PH_LEB: begin
          if (leb_room) begin
            acc_d     = acc_new;
            bit_pos_d = bp_new;
            if (!in_byte_q[7] || in_end_q) begin
              phase_d = PH_OPCODE;
            end
          end else if (!in_byte_q[7] || in_end_q) begin
            phase_d = PH_OPCODE;
          end else begin
            phase_d = PH_OVER;
          end
        end
        PH_OVER: begin
          if (!in_byte_q[7] || in_end_q) begin
            phase_d = PH_OPCODE;
          end
        end
        default: phase_d = PH_OPCODE;
      endcase
    end
  end

  // Result of the current beat.
  logic                     emit;
  logic [7:0]               res_op;
  logic [OPERAND_WIDTH-1:0] res_val;
  logic                     res_signed;
  err_e                     res_err;
  logic                     res_last;

  always_comb begin
    emit       = 1'b0;
    res_op     = held_op_q;
    res_val    = '0;
    res_signed = 1'b0;
    res_err    = ERR_OK;
    res_last   = in_end_q;
    case (phase_q)
      PH_OPCODE: begin
        res_op = in_byte_q;
        if (cls.kind == K_BAD) begin
          emit    = 1'b1;
          res_err = ERR_UNSUP;
        end else if (cls.kind == K_NONE) begin
          emit = 1'b1;
        end else if (in_end_q) begin
          // Operation cut off right after its opcode.
          emit    = 1'b1;
          res_err = ERR_TRUNC;
        end
      end
      PH_FIXED: begin
        if (bytes_dec == '0) begin
          emit       = 1'b1;
          res_val    = value;
          res_signed = is_signed_q;
        end else if (in_end_q) begin
          emit    = 1'b1;
          res_err = ERR_TRUNC;
        end
      end
      PH_LEB: begin
        if (leb_room) begin
          if (!in_byte_q[7]) begin
            emit       = 1'b1;
            res_val    = value;
            res_signed = is_signed_q;
          end else if (in_end_q) begin
            emit    = 1'b1;
            res_err = ERR_TRUNC;
          end
        end else if (!in_byte_q[7] || in_end_q) begin
          emit    = 1'b1;
          res_err = ERR_LEB_LONG;
        end
      end
      PH_OVER: begin
        if (!in_byte_q[7] || in_end_q) begin
          emit    = 1'b1;
          res_err = ERR_LEB_LONG;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_op_q    <= held_op_d;
    is_signed_q  <= is_signed_d;
    bytes_left_q <= bytes_left_d;
    acc_q        <= acc_d;
    bit_pos_q    <= bit_pos_d;
  end

  // Output register: filled by a beat that completes an instruction, emptied when taken.
  logic [OPERAND_OUT_W-1:0] operand_ext;

  assign operand_ext = res_signed ? OPERAND_OUT_W'($signed(res_val))
                                  : OPERAND_OUT_W'(res_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      m_axis_tdata <= {operand_ext, res_op};
      m_axis_tuser <= res_err;
      m_axis_tlast <= res_last;
    end
  end

endmodule

`default_nettype wire

>>> dv/dwarf_expression_decoder_tb.sv
// Self-checking testbench for the DWARF expression decoder: directed, random and stall tests.
module dwarf_expression_decoder_tb;
  import dexd_pkg::*;

  // DWARF operation codes that the stimulus and the decode predictor name.
  localparam logic [7:0] OP_ADDR         = 8'h03;
  localparam logic [7:0] OP_DEREF        = 8'h06;
  localparam logic [7:0] OP_CONST1U      = 8'h08;
  localparam logic [7:0] OP_CONST1S      = 8'h09;
  localparam logic [7:0] OP_CONST2U      = 8'h0a;
  localparam logic [7:0] OP_CONST2S      = 8'h0b;
  localparam logic [7:0] OP_CONST4U      = 8'h0c;
  localparam logic [7:0] OP_CONST4S      = 8'h0d;
  localparam logic [7:0] OP_CONST8U      = 8'h0e;
  localparam logic [7:0] OP_CONST8S      = 8'h0f;
  localparam logic [7:0] OP_CONSTU       = 8'h10;
  localparam logic [7:0] OP_CONSTS       = 8'h11;
  localparam logic [7:0] OP_DUP          = 8'h12;
  localparam logic [7:0] OP_DROP         = 8'h13;
  localparam logic [7:0] OP_OVER         = 8'h14;
  localparam logic [7:0] OP_PICK         = 8'h15;
  localparam logic [7:0] OP_SWAP         = 8'h16;
  localparam logic [7:0] OP_ROT          = 8'h17;
  localparam logic [7:0] OP_XDEREF       = 8'h18;
  localparam logic [7:0] OP_ABS          = 8'h19;
  localparam logic [7:0] OP_AND          = 8'h1a;
  localparam logic [7:0] OP_DIV          = 8'h1b;
  localparam logic [7:0] OP_MINUS        = 8'h1c;
  localparam logic [7:0] OP_MOD          = 8'h1d;
  localparam logic [7:0] OP_MUL          = 8'h1e;
  localparam logic [7:0] OP_NEG          = 8'h1f;
  localparam logic [7:0] OP_NOT          = 8'h20;
  localparam logic [7:0] OP_OR           = 8'h21;
  localparam logic [7:0] OP_PLUS         = 8'h22;
  localparam logic [7:0] OP_PLUS_UCONST  = 8'h23;
  localparam logic [7:0] OP_SHL          = 8'h24;
  localparam logic [7:0] OP_SHR          = 8'h25;
  localparam logic [7:0] OP_SHRA         = 8'h26;
  localparam logic [7:0] OP_XOR          = 8'h27;
  localparam logic [7:0] OP_BRA          = 8'h28;
  localparam logic [7:0] OP_EQ           = 8'h29;
  localparam logic [7:0] OP_GE           = 8'h2a;
  localparam logic [7:0] OP_GT           = 8'h2b;
  localparam logic [7:0] OP_LE           = 8'h2c;
  localparam logic [7:0] OP_LT           = 8'h2d;
  localparam logic [7:0] OP_NE           = 8'h2e;
  localparam logic [7:0] OP_SKIP         = 8'h2f;
  localparam logic [7:0] OP_LIT0         = 8'h30;
  localparam logic [7:0] OP_REG31        = 8'h6f;
  localparam logic [7:0] OP_BREG0        = 8'h70;
  localparam logic [7:0] OP_BREG31       = 8'h8f;
  localparam logic [7:0] OP_FBREG        = 8'h91;
  localparam logic [7:0] OP_DEREF_SIZE   = 8'h94;
  localparam logic [7:0] OP_XDEREF_SIZE  = 8'h95;
  localparam logic [7:0] OP_NOP          = 8'h96;
  localparam logic [7:0] OP_PUSH_OBJ     = 8'h97;
  localparam logic [7:0] OP_FORM_TLS     = 8'h9b;
  localparam logic [7:0] OP_CALL_CFA     = 8'h9c;
  localparam logic [7:0] OP_RESERVED_LO  = 8'h00;
  localparam logic [7:0] OP_RESERVED_HI  = 8'hff;

  // LEB128 limits for a 64-bit operand: ten groups, seventy bits.
  localparam int LEB_MAX_BITS = 70;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [7:0]  opcode;
    logic [63:0] operand;
    err_e        err;
    logic        last;
  } instr_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  dwarf_expression_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Decoder state as the predictor tracks it, reset values included.
  phase_e      st_phase       = PH_OPCODE;
  logic [7:0]  st_opcode      = 8'd0;
  kind_e       st_kind        = K_NONE;
  logic [3:0]  st_left        = 4'd0;
  logic [63:0] st_accum       = 64'd0;
  logic [6:0]  st_bitpos      = 7'd0;
  logic [3:0]  cfg_addr_bytes = ADDR_BYTES_RESET;

  // Instructions predicted but not yet seen on the master side, oldest first.
  instr_t pending_instrs[$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;

  int n_errors     = 0;
  int items_sent   = 0;
  int instrs_seen  = 0;
  int n_unsup      = 0;
  int n_overlong   = 0;
  int n_trunc      = 0;

  // Operand form of an opcode; nbytes gets the byte count of fixed forms.
  function automatic kind_e op_form(input logic [7:0] op, input logic [3:0] abytes,
                                    output logic [3:0] nbytes);
    nbytes = 4'd0;
    if (op >= OP_LIT0 && op <= OP_REG31) return K_NONE;
    if (op >= OP_BREG0 && op <= OP_BREG31) return K_SLEB;
    case (op)
      OP_DEREF, OP_DUP, OP_DROP, OP_OVER, OP_SWAP, OP_ROT, OP_XDEREF, OP_ABS,
      OP_AND, OP_DIV, OP_MINUS, OP_MOD, OP_MUL, OP_NEG, OP_NOT, OP_OR, OP_PLUS,
      OP_SHL, OP_SHR, OP_SHRA, OP_XOR, OP_EQ, OP_GE, OP_GT, OP_LE, OP_LT, OP_NE,
      OP_NOP, OP_PUSH_OBJ, OP_FORM_TLS, OP_CALL_CFA:
        return K_NONE;
      OP_CONST1U, OP_PICK, OP_DEREF_SIZE, OP_XDEREF_SIZE: begin
        nbytes = 4'd1;
        return K_FIXU;
      end
      OP_CONST1S: begin
        nbytes = 4'd1;
        return K_FIXS;
      end
      OP_CONST2U: begin
        nbytes = 4'd2;
        return K_FIXU;
      end
      OP_CONST2S, OP_BRA, OP_SKIP: begin
        nbytes = 4'd2;
        return K_FIXS;
      end
      OP_CONST4U: begin
        nbytes = 4'd4;
        return K_FIXU;
      end
      OP_CONST4S: begin
        nbytes = 4'd4;
        return K_FIXS;
      end
      OP_CONST8U: begin
        nbytes = 4'd8;
        return K_FIXU;
      end
      OP_CONST8S: begin
        nbytes = 4'd8;
        return K_FIXS;
      end
      OP_ADDR: begin
        // The address size is clamped to four through eight bytes.
        if (abytes < 4'd4) nbytes = 4'd4;
        else if (abytes > 4'd8) nbytes = 4'd8;
        else nbytes = abytes;
        return K_FIXU;
      end
      OP_CONSTU, OP_PLUS_UCONST: return K_ULEB;
      OP_CONSTS, OP_FBREG: return K_SLEB;
      default: return K_BAD;
    endcase
  endfunction

  function automatic logic [63:0] sign_fill(input logic [63:0] v, input int bits);
    logic [63:0] mask;
    if (bits == 0 || bits >= 64) return v;
    mask = (64'd1 << bits) - 64'd1;
    v = v & mask;
    if (v[bits-1]) v = v | ~mask;
    return v;
  endfunction

  function automatic void add_instr(input logic [7:0] op, input logic [63:0] val,
                                    input err_e err, input logic last);
    instr_t it;
    it.opcode  = op;
    it.operand = (err == ERR_OK) ? val : 64'd0;
    it.err     = err;
    it.last    = last;
    pending_instrs.push_back(it);
    if (last) st_phase = PH_OPCODE;
  endfunction

  // Advances the predicted decoder state by one accepted byte.
  function automatic void decode_step(input logic [7:0] b, input logic eoe);
    kind_e       k;
    logic [3:0]  n;
    logic [63:0] v;
    case (st_phase)
      PH_OPCODE: begin
        k = op_form(b, cfg_addr_bytes, n);
        if (k == K_BAD) begin
          add_instr(b, 64'd0, ERR_UNSUP, eoe);
        end else if (k == K_NONE) begin
          add_instr(b, 64'd0, ERR_OK, eoe);
        end else begin
          st_opcode = b;
          st_kind   = k;
          st_left   = n;
          st_accum  = 64'd0;
          st_bitpos = 7'd0;
          st_phase  = (k == K_FIXU || k == K_FIXS) ? PH_FIXED : PH_LEB;
          // An expression may end on an opcode that still wants its operand.
          if (eoe) add_instr(b, 64'd0, ERR_TRUNC, 1'b1);
        end
      end
      PH_FIXED: begin
        if (st_bitpos < 64) st_accum = st_accum | ({56'd0, b} << st_bitpos);
        st_bitpos = st_bitpos + 7'd8;
        if (st_left > 0) st_left = st_left - 4'd1;
        if (st_left == 0) begin
          v = (st_kind == K_FIXS) ? sign_fill(st_accum, st_bitpos) : st_accum;
          st_phase = PH_OPCODE;
          add_instr(st_opcode, v, ERR_OK, eoe);
        end else if (eoe) begin
          add_instr(st_opcode, 64'd0, ERR_TRUNC, 1'b1);
        end
      end
      PH_LEB: begin
        if (st_bitpos < LEB_MAX_BITS) begin
          // Bits of the tenth group above bit 63 fall away.
          if (st_bitpos < 64) st_accum = st_accum | ({57'd0, b[6:0]} << st_bitpos);
          st_bitpos = st_bitpos + 7'd7;
          if (!b[7]) begin
            v = st_accum;
            if (st_kind == K_SLEB && b[6] && st_bitpos < 64)
              v = v | ~((64'd1 << st_bitpos) - 64'd1);
            st_phase = PH_OPCODE;
            add_instr(st_opcode, v, ERR_OK, eoe);
          end else if (eoe) begin
            add_instr(st_opcode, 64'd0, ERR_TRUNC, 1'b1);
          end
        end else begin
          st_phase = PH_OVER;
          if (!b[7] || eoe) begin
            st_phase = PH_OPCODE;
            add_instr(st_opcode, 64'd0, ERR_LEB_LONG, eoe);
          end
        end
      end
      default: begin
        // Overlong LEB128: swallow bytes until the group chain or the expression ends.
        if (!b[7] || eoe) begin
          st_phase = PH_OPCODE;
          add_instr(st_opcode, 64'd0, ERR_LEB_LONG, eoe);
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Every instruction beat is matched against the oldest prediction.
  always @(posedge clk_i) begin : instr_check
    instr_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      instrs_seen++;
      case (m_axis_tuser)
        ERR_UNSUP:    n_unsup++;
        ERR_LEB_LONG: n_overlong++;
        ERR_TRUNC:    n_trunc++;
        default: ;
      endcase
      if (pending_instrs.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected instruction, expected none, got opcode %h operand %h",
                 $time, m_axis_tdata[7:0], m_axis_tdata[71:8]);
      end else begin
        want = pending_instrs.pop_front();
        check_field("opcode", {56'd0, want.opcode}, {56'd0, m_axis_tdata[7:0]});
        check_field("operand", want.operand, m_axis_tdata[71:8]);
        check_field("error_code", {62'd0, want.err}, {62'd0, m_axis_tuser});
        check_field("last_instr", {63'd0, want.last}, {63'd0, m_axis_tlast});
      end
    end
  end

  // Offers one byte, with a random idle gap first, and waits for its beat.
  task automatic push_byte(input logic [7:0] b, input logic eoe);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoe;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    decode_step(b, eoe);
  endtask

  // Stops offering and waits until every predicted instruction has come out.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_instrs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_addr_bytes(input logic [3:0] v);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cfg_addr_bytes = v;
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    case ($urandom_range(4))
      0: op = 8'($urandom_range(255));
      1: op = 8'($urandom_range(OP_DEREF, OP_SKIP));
      2: op = 8'($urandom_range(OP_LIT0, OP_REG31));
      3: begin
        case ($urandom_range(13))
          0:  op = OP_ADDR;
          1:  op = OP_CONST1U;
          2:  op = OP_CONST1S;
          3:  op = OP_CONST2U;
          4:  op = OP_CONST2S;
          5:  op = OP_CONST4U;
          6:  op = OP_CONST4S;
          7:  op = OP_CONST8U;
          8:  op = OP_CONST8S;
          9:  op = OP_PICK;
          10: op = OP_BRA;
          11: op = OP_SKIP;
          12: op = OP_DEREF_SIZE;
          default: op = OP_XDEREF_SIZE;
        endcase
      end
      default: begin
        case ($urandom_range(4))
          0: op = OP_CONSTU;
          1: op = OP_PLUS_UCONST;
          2: op = OP_CONSTS;
          3: op = OP_FBREG;
          default: op = 8'($urandom_range(OP_BREG0, OP_BREG31));
        endcase
      end
    endcase
    return op;
  endfunction

  // Builds one expression of random operations with random operands, unsupported
  // codes and overlong LEB128 included; now and then it is cut short at a random byte.
  task automatic send_expr();
    logic [7:0] bytes[$];
    logic [7:0] op;
    logic [6:0] grp;
    logic [3:0] n;
    kind_e      k;
    int         n_ops;
    int         groups;
    int         r;
    int         keep;
    n_ops = $urandom_range(1, 5);
    for (int i = 0; i < n_ops; i++) begin
      op = pick_opcode();
      bytes.push_back(op);
      k = op_form(op, cfg_addr_bytes, n);
      if (k == K_FIXU || k == K_FIXS) begin
        repeat (n) bytes.push_back(8'($urandom_range(255)));
      end else if (k == K_ULEB || k == K_SLEB) begin
        r = $urandom_range(99);
        if (r < 60) groups = $urandom_range(1, 2);
        else if (r < 85) groups = $urandom_range(3, 9);
        else if (r < 93) groups = 10;
        else groups = $urandom_range(11, 14);
        for (int g = 0; g < groups; g++) begin
          grp = 7'($urandom_range(127));
          bytes.push_back({(g != groups - 1) ? 1'b1 : 1'b0, grp});
        end
      end
    end
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(1, bytes.size());
      while (bytes.size() > keep) bytes.delete(bytes.size() - 1);
    end
    foreach (bytes[j]) push_byte(bytes[j], j == bytes.size() - 1);
  endtask

  // Edge cases: unsupported codes at both ends of the byte range, sign
  // extension of a one-byte constant, a one-group negative SLEB128, a two-group
  // ULEB128, an expression ending on an opcode, one ending mid-constant and
  // an overlong ULEB128 closed by a group with its continuation bit clear.
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    push_byte(OP_LIT0, 1'b0);
    push_byte(OP_RESERVED_LO, 1'b0);
    push_byte(OP_RESERVED_HI, 1'b0);
    push_byte(OP_CONST1S, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(OP_CONSTS, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(OP_CONSTU, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(OP_CONST4U, 1'b1);
    push_byte(OP_CONST2U, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(OP_CONSTU, 1'b0);
    repeat (10) push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_drain();
  endtask

  // Address operands under every interesting register value, clamps included.
  task automatic test_addr_sizes();
    logic [3:0] sizes[8];
    logic [3:0] n;
    sizes = '{4'd0, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8, 4'd9, 4'd15};
    foreach (sizes[i]) begin
      write_addr_bytes(sizes[i]);
      void'(op_form(OP_ADDR, cfg_addr_bytes, n));
      push_byte(OP_ADDR, 1'b0);
      for (int b = 0; b < n; b++) push_byte(8'($urandom_range(255)), b == n - 1);
      send_expr();
    end
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int n_items);
    int stop_at;
    write_addr_bytes(4'($urandom_range(15)));
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_expr();
    wait_drain();
  endtask

  // The receiver holds off long enough for the decoder to fill and stall its
  // input while the sender keeps offering; then the sender waits for the drain.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 400;
    repeat (39) push_byte(8'($urandom_range(OP_LIT0, OP_REG31)), 1'b0);
    push_byte(OP_NOP, 1'b1);
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_addr_sizes();
    test_random(0, 0, 260);
    test_random(59, 0, 260);
    test_random(0, 59, 260);
    test_random(21, 21, 260);
    test_backpressure();
    wait_drain();
    $display("Checked %0d instructions from %0d bytes: %0d unsupported, %0d overlong LEB128,",
             instrs_seen, items_sent, n_unsup, n_overlong);
    $display("%0d truncated; address sizes 0 to 15, four stall mixes and a long hold-off.",
             n_trunc);
    if (n_errors == 0) begin
      $display("dwarf_expression_decoder_tb: clean");
    end else begin
      $display("dwarf_expression_decoder_tb: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("%0t: timeout, %0d instructions still pending", $time, pending_instrs.size());
    $display("dwarf_expression_decoder_tb: errors");
    $finish;
  end

endmodule
